// ===== rtl/s256_pkg.sv =====
// SHA-256 hasher package: widths, constant tables and round functions.
package s256_pkg;

   localparam int WordBits      = 32;
   localparam int DefLenBits    = 64;
   localparam int BlkWords      = 16;
   localparam int HashWords     = 8;
   localparam int Rounds        = 64;

   typedef logic [WordBits-1:0] word_type;
   typedef logic [HashWords-1:0][WordBits-1:0] work_type;
   typedef logic [BlkWords-1:0][WordBits-1:0] window_type;

   localparam logic [7:0] PadByte = 8'h80;

   // round constants
   localparam logic [Rounds-1:0][31:0] RoundConst = {
      32'hc67178f2, 32'hbef9a3f7, 32'ha4506ceb, 32'h90befffa,
      32'h8cc70208, 32'h84c87814, 32'h78a5636f, 32'h748f82ee,
      32'h682e6ff3, 32'h5b9cca4f, 32'h4ed8aa4a, 32'h391c0cb3,
      32'h34b0bcb5, 32'h2748774c, 32'h1e376c08, 32'h19a4c116,
      32'h106aa070, 32'hf40e3585, 32'hd6990624, 32'hd192e819,
      32'hc76c51a3, 32'hc24b8b70, 32'ha81a664b, 32'ha2bfe8a1,
      32'h92722c85, 32'h81c2c92e, 32'h766a0abb, 32'h650a7354,
      32'h53380d13, 32'h4d2c6dfc, 32'h2e1b2138, 32'h27b70a85,
      32'h14292967, 32'h06ca6351, 32'hd5a79147, 32'hc6e00bf3,
      32'hbf597fc7, 32'hb00327c8, 32'ha831c66d, 32'h983e5152,
      32'h76f988da, 32'h5cb0a9dc, 32'h4a7484aa, 32'h2de92c6f,
      32'h240ca1cc, 32'h0fc19dc6, 32'hefbe4786, 32'he49b69c1,
      32'hc19bf174, 32'h9bdc06a7, 32'h80deb1fe, 32'h72be5d74,
      32'h550c7dc3, 32'h243185be, 32'h12835b01, 32'hd807aa98,
      32'hab1c5ed5, 32'h923f82a4, 32'h59f111f1, 32'h3956c25b,
      32'he9b5dba5, 32'hb5c0fbcf, 32'h71374491, 32'h428a2f98};

   // initial hash values
   localparam logic [HashWords-1:0][31:0] InitHash = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

   function automatic word_type rotr(input word_type x, input int n);
      return (x >> n) | (x << (WordBits - n));
   endfunction

   function automatic word_type sig0(input word_type x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type sig1(input word_type x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

endpackage

// ===== rtl/sha256_message_hasher_core.sv =====
// SHA-256 hasher top level: byte gathering, padding, compression sequencer, digest output.
// Sequence: a word that fills a block starts a compression: ST_LOAD fetches the chaining words,
// ST_ROUND runs 64 rounds (one per cycle) and ST_ADD adds back, word by word, set by the single
// chaining RAM ports. An end word adds padding writes, one or two compressions and 8 digest
// words, each held until the sink is ready, then the initial hash is loaded again.
// Throughput: one byte word per cycle while idle; input stalls during compression, padding and output.
// Reset: synchronous, active high; after reset, ST_INIT loads the initial hash.
module sha256_message_hasher_core #(
   parameter int LENGTH_COUNTER_BITS = s256_pkg::DefLenBits
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] byte_valid
   input  logic        req_tlast,   // end_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] digest_word, [34:32] word_index, [39:35] zero
   output logic        rsp_tlast    // last_word
);
   import s256_pkg::*;

   typedef enum logic [3:0] {
      ST_INIT, ST_IDLE, ST_PAD, ST_ZERO, ST_LEN_HI, ST_LEN_LO,
      ST_LOAD, ST_ROUND, ST_ADD, ST_OUT_RD, ST_OUT_CAP, ST_OUT_WAIT
   } state_type;

   state_type state_ff, state_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [LENGTH_COUNTER_BITS-1:0] bits_ff, bits_in;
   word_type    acc_ff, acc_in;
   logic [3:0]  seq_ff, seq_in;
   logic [5:0]  rnd_ff, rnd_in;
   logic [4:0]  wptr_ff, wptr_in;
   logic [2:0]  idx_ff, idx_in;
   logic        pend_ff, pend_in;
   logic        two_ff, two_in;
   logic        final_ff, final_in;
   logic        rvalid_ff, rvalid_in;
   word_type    rword_ff, rword_in;
   work_type    work_ff, work_in;
   window_type  win_ff, win_in;

   logic        blk_we, ch_we;
   logic [3:0]  blk_waddr, blk_raddr;
   logic [2:0]  ch_waddr, ch_raddr;
   word_type    blk_wdata, blk_rdata, ch_wdata, ch_rdata;
   work_type    rnd_work;
   window_type  rnd_win;
   logic [63:0] len64;
   logic [1:0]  lane;
   logic [3:0]  pad_wi;
   logic [4:0]  zlimit;

   s256_ram #(.WIDTH(WordBits), .DEPTH(BlkWords)) u_blk_ram (
      .clock(clock), .wr_en(blk_we), .wr_addr(blk_waddr), .wr_data(blk_wdata),
      .rd_addr(blk_raddr), .rd_data(blk_rdata));

   s256_ram #(.WIDTH(WordBits), .DEPTH(HashWords)) u_chain_ram (
      .clock(clock), .wr_en(ch_we), .wr_addr(ch_waddr), .wr_data(ch_wdata),
      .rd_addr(ch_raddr), .rd_data(ch_rdata));

   s256_round u_round (
      .work(work_ff), .window(win_ff), .blk_word(blk_rdata), .rnd(rnd_ff),
      .work_next(rnd_work), .window_next(rnd_win));

   assign len64      = 64'(bits_ff);
   assign lane       = cnt_ff[1:0];
   assign pad_wi     = cnt_ff[5:2];
   assign zlimit     = two_ff ? 5'd15 : 5'd13;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = {5'b0, idx_ff, rword_ff};
   assign rsp_tlast  = (idx_ff == 3'd7);

   // sequencer next state and RAM controls
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      bits_in   = bits_ff;
      acc_in    = acc_ff;
      seq_in    = seq_ff;
      rnd_in    = rnd_ff;
      wptr_in   = wptr_ff;
      idx_in    = idx_ff;
      pend_in   = pend_ff;
      two_in    = two_ff;
      final_in  = final_ff;
      rvalid_in = rvalid_ff;
      rword_in  = rword_ff;
      work_in   = work_ff;
      win_in    = win_ff;
      blk_we    = 1'b0;
      blk_waddr = wptr_ff[3:0];
      blk_wdata = '0;
      blk_raddr = '0;
      ch_we     = 1'b0;
      ch_waddr  = seq_ff[2:0] - 3'd1;
      ch_wdata  = ch_rdata + work_ff[0];
      ch_raddr  = seq_ff[2:0];
      case (state_ff)
         ST_INIT: begin
            ch_we    = 1'b1;
            ch_waddr = seq_ff[2:0];
            ch_wdata = InitHash[seq_ff[2:0]];
            seq_in   = seq_ff + 4'd1;
            if (seq_ff == 4'd7) begin
               state_in = ST_IDLE;
               seq_in   = '0;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser) begin
                  // big-endian byte gathering into a 32-bit word
                  if (lane == 2'd0) begin
                     acc_in = {req_tdata, 24'h0};
                  end else begin
                     acc_in = acc_ff | (word_type'(req_tdata) << {2'd3 - lane, 3'b000});
                  end
                  blk_we    = (lane == 2'd3);
                  blk_waddr = pad_wi;
                  blk_wdata = acc_in;
                  cnt_in    = cnt_ff + 6'd1;
                  bits_in   = bits_ff + LENGTH_COUNTER_BITS'(8);
                  if (cnt_ff == 6'd63) begin
                     state_in = ST_LOAD;
                     seq_in   = '0;
                     pend_in  = req_tlast;
                  end else if (req_tlast) begin
                     state_in = ST_PAD;
                  end
               end else if (req_tlast) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            // partial word with the pad byte after the last data byte
            blk_we    = 1'b1;
            blk_waddr = pad_wi;
            if (lane == 2'd0) begin
               blk_wdata = {PadByte, 24'h0};
            end else begin
               blk_wdata = acc_ff | (word_type'(PadByte) << {2'd3 - lane, 3'b000});
            end
            wptr_in  = {1'b0, pad_wi} + 5'd1;
            two_in   = (pad_wi >= 4'd14);
            state_in = ST_ZERO;
         end
         ST_ZERO: begin
            if (wptr_ff <= zlimit) begin
               blk_we    = 1'b1;
               blk_waddr = wptr_ff[3:0];
               blk_wdata = '0;
               wptr_in   = wptr_ff + 5'd1;
            end else if (two_ff) begin
               state_in = ST_LOAD;
               seq_in   = '0;
            end else begin
               state_in = ST_LEN_HI;
            end
         end
         ST_LEN_HI: begin
            blk_we    = 1'b1;
            blk_waddr = 4'd14;
            blk_wdata = len64[63:32];
            state_in  = ST_LEN_LO;
         end
         ST_LEN_LO: begin
            blk_we    = 1'b1;
            blk_waddr = 4'd15;
            blk_wdata = len64[31:0];
            final_in  = 1'b1;
            state_in  = ST_LOAD;
            seq_in    = '0;
         end
         ST_LOAD: begin
            // chaining words into the working registers
            if (seq_ff != 4'd0) begin
               work_in = {ch_rdata, work_ff[HashWords-1:1]};
            end
            seq_in = seq_ff + 4'd1;
            if (seq_ff == 4'd8) begin
               blk_raddr = '0;
               state_in  = ST_ROUND;
               rnd_in    = '0;
               seq_in    = '0;
            end
         end
         ST_ROUND: begin
            blk_raddr = rnd_ff[3:0] + 4'd1;
            work_in   = rnd_work;
            win_in    = rnd_win;
            rnd_in    = rnd_ff + 6'd1;
            if (rnd_ff == 6'd63) begin
               state_in = ST_ADD;
               seq_in   = '0;
            end
         end
         ST_ADD: begin
            // read chaining word, write back the sum in the following cycle
            if (seq_ff != 4'd0) begin
               ch_we   = 1'b1;
               work_in = {ch_rdata, work_ff[HashWords-1:1]};
            end
            seq_in = seq_ff + 4'd1;
            if (seq_ff == 4'd8) begin
               seq_in = '0;
               if (final_ff) begin
                  final_in = 1'b0;
                  idx_in   = '0;
                  state_in = ST_OUT_RD;
               end else if (two_ff) begin
                  two_in   = 1'b0;
                  wptr_in  = '0;
                  state_in = ST_ZERO;
               end else if (pend_ff) begin
                  pend_in  = 1'b0;
                  state_in = ST_PAD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_OUT_RD: begin
            ch_raddr = idx_ff;
            state_in = ST_OUT_CAP;
         end
         ST_OUT_CAP: begin
            rword_in  = ch_rdata;
            rvalid_in = 1'b1;
            state_in  = ST_OUT_WAIT;
         end
         ST_OUT_WAIT: begin
            if (rsp_tready) begin
               rvalid_in = 1'b0;
               if (idx_ff == 3'd7) begin
                  state_in = ST_INIT;
                  seq_in   = '0;
                  cnt_in   = '0;
                  bits_in  = '0;
               end else begin
                  idx_in   = idx_ff + 3'd1;
                  state_in = ST_OUT_RD;
               end
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_INIT;
         cnt_ff    <= '0;
         bits_ff   <= '0;
         seq_ff    <= '0;
         rnd_ff    <= '0;
         wptr_ff   <= '0;
         idx_ff    <= '0;
         pend_ff   <= 1'b0;
         two_ff    <= 1'b0;
         final_ff  <= 1'b0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         bits_ff   <= bits_in;
         seq_ff    <= seq_in;
         rnd_ff    <= rnd_in;
         wptr_ff   <= wptr_in;
         idx_ff    <= idx_in;
         pend_ff   <= pend_in;
         two_ff    <= two_in;
         final_ff  <= final_in;
         rvalid_ff <= rvalid_in;
      end
      acc_ff   <= acc_in;
      rword_ff <= rword_in;
      work_ff  <= work_in;
      win_ff   <= win_in;
   end

`ifndef SYNTHESIS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid)
      else $error("input taken while digest pending");

   a_last_word_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (!rsp_tvalid && !req_tready))
      else $error("digest end not followed by re-init");

   a_round_wrap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && rnd_ff == 6'd63) |=> (state_ff == ST_ADD))
      else $error("compression did not end after last round");
`endif

endmodule

// ===== rtl/s256_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module s256_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/s256_round.sv =====
// One SHA-256 round: schedule word generation and working word update.
module s256_round (
   input  s256_pkg::work_type   work,
   input  s256_pkg::window_type window,
   input  s256_pkg::word_type   blk_word,
   input  logic [5:0]           rnd,
   output s256_pkg::work_type   work_next,
   output s256_pkg::window_type window_next
);
   import s256_pkg::*;

   word_type w, big_s0, big_s1, ch, maj, t1, t2;

   // schedule word: block word for the first 16 rounds, then expansion
   always_comb begin
      if (rnd < 6'(BlkWords)) begin
         w = blk_word;
      end else begin
         w = window[0] + sig0(window[1]) + window[9] + sig1(window[14]);
      end
      window_next = {w, window[BlkWords-1:1]};
   end

   // compression round
   always_comb begin
      big_s1 = rotr(work[4], 6) ^ rotr(work[4], 11) ^ rotr(work[4], 25);
      ch     = (work[4] & work[5]) ^ (~work[4] & work[6]);
      t1     = work[7] + big_s1 + ch + RoundConst[rnd] + w;
      big_s0 = rotr(work[0], 2) ^ rotr(work[0], 13) ^ rotr(work[0], 22);
      maj    = (work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]);
      t2     = big_s0 + maj;
      work_next[7] = work[6];
      work_next[6] = work[5];
      work_next[5] = work[4];
      work_next[4] = work[3] + t1;
      work_next[3] = work[2];
      work_next[2] = work[1];
      work_next[1] = work[0];
      work_next[0] = t1 + t2;
   end

endmodule

// ===== verif/tb_sha256_message_hasher_core.sv =====
// Testbench for the SHA-256 message hasher: streams byte words, checks digest words.
module tb_sha256_message_hasher_core;
   timeunit 1ns;
   timeprecision 1ps;
   import s256_pkg::*;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       end_of_message;
   } byte_word_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } digest_word_type;

   localparam int CycleLimit = 2000000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tuser;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;

   sha256_message_hasher_core DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   byte_word_type   pending_words[$];
   digest_word_type expected_digests[$];
   int              fail_count;
   int              cycle_count;
   bit              quiet_mode;
   bit              hold_sender;
   bit              req_taken;
   int              send_gap;
   int              sink_gap;

   // hasher state mirror
   logic [31:0] chain_h[8];
   logic [7:0]  block_bytes[64];
   logic [5:0]  block_fill;
   logic [63:0] bit_length;

   function automatic logic [31:0] rot_right(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic restart_message();
      chain_h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                  32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      block_fill = '0;
      bit_length = '0;
   endtask

   task automatic compress_block();
      logic [31:0] sched[64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
      for (int t = 0; t < 16; t++)
         sched[t] = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2],
                     block_bytes[4*t+3]};
      for (int t = 16; t < 64; t++)
         sched[t] = sched[t-16] + sched[t-7]
                  + (rot_right(sched[t-15], 7) ^ rot_right(sched[t-15], 18)
                     ^ (sched[t-15] >> 3))
                  + (rot_right(sched[t-2], 17) ^ rot_right(sched[t-2], 19)
                     ^ (sched[t-2] >> 10));
      {a, b, c, d, e, f, g, h} = {chain_h[0], chain_h[1], chain_h[2], chain_h[3],
                                  chain_h[4], chain_h[5], chain_h[6], chain_h[7]};
      for (int t = 0; t < 64; t++) begin
         t1 = h + (rot_right(e, 6) ^ rot_right(e, 11) ^ rot_right(e, 25))
            + ((e & f) ^ (~e & g)) + RoundConst[t] + sched[t];
         t2 = (rot_right(a, 2) ^ rot_right(a, 13) ^ rot_right(a, 22))
            + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
      end
      chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
      chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
   endtask

   // advance the mirror by one accepted word, queueing digest words on end of message
   task automatic hash_byte_word(byte_word_type w);
      int n;
      digest_word_type d;
      if (w.byte_valid) begin
         block_bytes[block_fill] = w.data_byte;
         block_fill++;
         bit_length += 8;
         if (block_fill == 0) compress_block();
      end
      if (!w.end_of_message) return;
      n = block_fill;
      block_bytes[n++] = PadByte;
      if (n > 56) begin
         while (n < 64) block_bytes[n++] = '0;
         compress_block();
         n = 0;
      end
      while (n < 56) block_bytes[n++] = '0;
      for (int i = 0; i < 8; i++) block_bytes[56+i] = bit_length[63-8*i -: 8];
      compress_block();
      for (int i = 0; i < 8; i++) begin
         d.digest_word = chain_h[i];
         d.word_index = 3'(i);
         d.last_word = (i == 7);
         expected_digests.push_back(d);
      end
      restart_message();
   endtask

   task automatic add_message(int len, bit empty_end);
      byte_word_type w;
      for (int i = 0; i < len; i++) begin
         w.data_byte = 8'($urandom);
         w.byte_valid = 1'b1;
         w.end_of_message = (i == len - 1) && !empty_end;
         pending_words.push_back(w);
         // sprinkle idle words into the stream
         if ($urandom_range(0, 15) == 0) pending_words.push_back('{8'($urandom), 1'b0, 1'b0});
      end
      if (empty_end || len == 0) pending_words.push_back('{8'($urandom), 1'b0, 1'b1});
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // word driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_taken) begin
         // hold the current word
      end else if (send_gap > 0) begin
         send_gap <= send_gap - 1;
         req_tvalid <= 1'b0;
      end else if (!hold_sender && pending_words.size() > 0) begin
         {req_tdata, req_tuser, req_tlast} <= pending_words.pop_front();
         req_tvalid <= 1'b1;
         if (!quiet_mode && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 15);
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // sink stall
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (sink_gap > 0) begin
         sink_gap <= sink_gap - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!quiet_mode && $urandom_range(0, 9) == 0) sink_gap <= $urandom_range(1, 15);
      end
   end

   // monitor: predict on input accept, compare on output accept
   always @(posedge clock) begin
      digest_word_type exp_word;
      cycle_count <= cycle_count + 1;
      req_taken <= !reset && req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready)
         hash_byte_word('{req_tdata, req_tuser, req_tlast});
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_digests.size() == 0) begin
            $error("digest word with none expected: %h", rsp_tdata);
            fail_count++;
         end else begin
            exp_word = expected_digests.pop_front();
            if (rsp_tdata[31:0] !== exp_word.digest_word) begin
               $error("digest_word expected %h actual %h", exp_word.digest_word,
                      rsp_tdata[31:0]);
               fail_count++;
            end
            if (rsp_tdata[34:32] !== exp_word.word_index) begin
               $error("word_index expected %0d actual %0d", exp_word.word_index,
                      rsp_tdata[34:32]);
               fail_count++;
            end
            if (rsp_tlast !== exp_word.last_word) begin
               $error("last_word expected %0d actual %0d", exp_word.last_word, rsp_tlast);
               fail_count++;
            end
         end
      end
   end

   // timeout
   always @(posedge clock) begin
      if (cycle_count > CycleLimit) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      fail_count = 0;
      cycle_count = 0;
      quiet_mode = 1'b0;
      hold_sender = 1'b1;
      req_taken = 1'b0;
      send_gap = 0;
      sink_gap = 0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      req_tlast = 1'b0;
      rsp_tready = 1'b0;
      restart_message();
      reset = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty message, idle word, extremes, one- and three-byte messages
      pending_words.push_back('{8'h00, 1'b0, 1'b0});
      pending_words.push_back('{8'hff, 1'b0, 1'b1});
      pending_words.push_back('{8'hff, 1'b1, 1'b1});
      pending_words.push_back('{8'h00, 1'b1, 1'b0});
      pending_words.push_back('{8'h55, 1'b1, 1'b0});
      pending_words.push_back('{8'haa, 1'b1, 1'b1});
      hold_sender = 1'b0;
      wait (pending_words.size() == 0 && expected_digests.size() == 0);

      // block-boundary lengths, then sender holds until all digests drain
      add_message(55, 0);
      add_message(56, 0);
      add_message(64, 0);
      add_message(64, 1);
      wait (pending_words.size() == 0 && !req_tvalid);
      hold_sender = 1'b1;
      wait (expected_digests.size() == 0);
      hold_sender = 1'b0;

      // random messages, mostly short
      for (int m = 0; m < 10; m++)
         add_message($urandom_range(0, 3) == 0 ? $urandom_range(0, 70)
                                               : $urandom_range(0, 12),
                     $urandom_range(0, 3) == 0);
      // last stretch with no sender or sink gaps
      wait (pending_words.size() < 30);
      quiet_mode = 1'b1;
      add_message(20, 0);
      add_message(0, 1);

      wait (pending_words.size() == 0 && !req_tvalid);
      wait (expected_digests.size() == 0);
      repeat (300) @(posedge clock);
      if (fail_count == 0 && expected_digests.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
